// ----- rtl/rpai_pkg.sv -----
package rpai_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER  = 3'd0,
        REG_NORMAL  = 3'd1,
        REG_INNER   = 3'd2,
        REG_OUTER   = 3'd3,
        REG_AZ_LOW  = 3'd4,
        REG_AZ_HIGH = 3'd5
    } cfg_reg_t;

    localparam int CFG_W    = 48;
    localparam int LANE_W   = 16;
    localparam int NORM_W   = 16;
    localparam int RAD_W    = 32;
    localparam int AZ_W     = 17;
    localparam int T_W      = 32;
    localparam int FRAC_W   = 16;
    localparam int E_W      = 25;
    localparam int CORDIC_N = 31;
    localparam int NORM_TOP = 40;
    localparam int NORM_N   = 7;

    localparam logic [T_W-1:0]   EPS_T     = 32'd65;
    localparam logic [E_W-1:0]   E_MAX     = 25'h100_0000;
    localparam logic [31:0]      HALF_TURN = 32'h8000_0000;

    localparam logic [CFG_W-1:0] CENTER_RST = 48'd0;
    localparam logic [CFG_W-1:0] NORMAL_RST = 48'h0000_4000_0000;
    localparam logic [RAD_W-1:0] INNER_RST  = 32'h0001_0000;
    localparam logic [RAD_W-1:0] OUTER_RST  = 32'h0004_0000;
    localparam logic [AZ_W-1:0]  AZ_LOW_RST = 17'd0;
    localparam logic [AZ_W-1:0]  AZ_HI_RST  = 17'h1_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [CORDIC_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

endpackage

// ----- rtl/rpai_div_cell.sv -----
module rpai_div_cell #(
    parameter int DW = 34,
    parameter int PW = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [DW-1:0]            in_rem,
    input  logic [DW-1:0]            in_div,
    input  logic [rpai_pkg::T_W-1:0] in_bits,
    input  logic [rpai_pkg::T_W-1:0] in_quo,
    input  logic [PW-1:0]            in_pay,
    output logic                     out_valid,
    output logic [DW-1:0]            out_rem,
    output logic [DW-1:0]            out_div,
    output logic [rpai_pkg::T_W-1:0] out_bits,
    output logic [rpai_pkg::T_W-1:0] out_quo,
    output logic [PW-1:0]            out_pay
);
    import rpai_pkg::*;

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg;
    logic [T_W-1:0] bits_reg, quo_reg, quo_next;
    logic [PW-1:0] pay_reg;
    logic [DW:0]   trial, diff;
    logic          ge;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {in_rem, in_bits[T_W-1]};
        diff     = trial - {1'b0, in_div};
        ge       = trial >= {1'b0, in_div};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {in_quo[T_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            bits_reg <= {in_bits[T_W-2:0], 1'b0};
            quo_reg  <= quo_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_bits  = bits_reg;
    assign out_quo   = quo_reg;
    assign out_pay   = pay_reg;

endmodule

// ----- rtl/rpai_norm_cell.sv -----
module rpai_norm_cell #(
    parameter int CW        = 56,
    parameter int PW        = 8,
    parameter int SHIFT     = 1,
    parameter int LIMIT_BIT = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic [PW-1:0]        out_pay
);
    localparam logic [CW-1:0] LIMIT = CW'(1) << LIMIT_BIT;

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [PW-1:0]        pay_reg;
    logic [CW-1:0]        mx, my;
    logic                 do_shift;

    // shift both axes up while the larger magnitude stays below the limit
    always_comb
    begin
        mx       = in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
        my       = in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
        do_shift = (mx | my) < LIMIT;
        x_next   = do_shift ? (in_x <<< SHIFT) : in_x;
        y_next   = do_shift ? (in_y <<< SHIFT) : in_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_pay   = pay_reg;

endmodule

// ----- rtl/rpai_cordic_cell.sv -----
module rpai_cordic_cell #(
    parameter int CW   = 56,
    parameter int PW   = 8,
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic [31:0]          in_ang,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic [31:0]          out_ang,
    output logic [PW-1:0]        out_pay
);
    import rpai_pkg::*;

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic [31:0]          ang_reg, ang_next;
    logic [PW-1:0]        pay_reg;
    logic                 y_pos;

    // vectoring rotation: drive y toward zero, accumulate the angle
    always_comb
    begin
        xs    = in_x >>> STEP;
        ys    = in_y >>> STEP;
        y_pos = !in_y[CW-1] && (in_y != '0);
        if (y_pos)
        begin
            x_next   = in_x + ys;
            y_next   = in_y - xs;
            ang_next = in_ang + ATAN_TURN[STEP];
        end
        else
        begin
            x_next   = in_x - ys;
            y_next   = in_y + xs;
            ang_next = in_ang - ATAN_TURN[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ang   = ang_reg;
    assign out_pay   = pay_reg;

endmodule

// ----- rtl/ray_part_annulus_intersect_top.sv -----
// Ray against partial annulus. One ray request per clock is accepted
// (s_tready stays high unless the output skid slot is occupied) and every
// request yields exactly one result. The pipeline holds three setup stages
// for the plane dot products, a row of 32 restoring divider cells that
// produce t in Q16.16 one bit per cell, five stages for the hit point,
// offset magnitudes and squared distance, seven normalizing shift cells
// and 31 CORDIC cells for the azimuth atan2(x, z), and the output
// register. The user must write configuration registers through
// cfg_wen/cfg_index/cfg_wdata only while the block is idle; the block itself
// does not enforce it. A miss returns hit = 0 with all other fields zero.
module ray_part_annulus_intersect_top #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_STEPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // tdata fields from the low bit: origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z, each COORD_WIDTH signed
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    // tdata fields from the low bit: hit, distance (32), hit_x, hit_y,
    // hit_z (COORD_WIDTH each), normal_flipped
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((3*COORD_WIDTH+34+7)/8)*8-1:0]    m_tdata,
    input  logic                                     cfg_wen,
    input  logic [2:0]                               cfg_index,
    input  logic [rpai_pkg::CFG_W-1:0]               cfg_wdata
);
    import rpai_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int A     = ANGLE_STEPS;
    localparam int OUT_W = ((3*W+34+7)/8)*8;
    localparam int CO_W  = ((W > LANE_W) ? W : LANE_W) + 1;
    localparam int PN_W  = CO_W + NORM_W;
    localparam int PD_W  = W + NORM_W;
    localparam int NUM_W = PN_W + 2;
    localparam int DEN_W = PD_W + 2;
    localparam int P_W   = W + 18;
    localparam int SQ_W  = 2*E_W + 2;
    localparam int CW    = ((P_W - 1 > NORM_TOP + 1) ? P_W - 1 : NORM_TOP + 1) + 4;
    localparam int PH_W  = ((A + 1) > AZ_W) ? A + 1 : AZ_W;
    localparam int DIV_N = T_W;
    // divider payload: o[3], d[3], live, flip, ovf
    localparam int PWD   = 6*W + 3;
    // azimuth payload: t, psat[3], live, flip, neg, zero
    localparam int PWA   = T_W + 3*W + 4;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] center_reg, normal_reg;
    logic [RAD_W-1:0] inner_reg, outer_reg;
    logic [AZ_W-1:0]  az_low_reg, az_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= CENTER_RST;
            normal_reg  <= NORMAL_RST;
            inner_reg   <= INNER_RST;
            outer_reg   <= OUTER_RST;
            az_low_reg  <= AZ_LOW_RST;
            az_high_reg <= AZ_HI_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER:  center_reg  <= cfg_wdata;
                REG_NORMAL:  normal_reg  <= cfg_wdata;
                REG_INNER:   inner_reg   <= cfg_wdata[RAD_W-1:0];
                REG_OUTER:   outer_reg   <= cfg_wdata[RAD_W-1:0];
                REG_AZ_LOW:  az_low_reg  <= cfg_wdata[AZ_W-1:0];
                REG_AZ_HIGH: az_high_reg <= cfg_wdata[AZ_W-1:0];
                default:     ;
            endcase
        end
    end

    logic signed [LANE_W-1:0] cen [3];
    logic signed [NORM_W-1:0] nrm [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cen[k] = center_reg[k*LANE_W +: LANE_W];
            nrm[k] = normal_reg[k*NORM_W +: NORM_W];
        end
    end

    // ---------------- flow control ----------------
    // whole pipeline moves together; it halts only when the skid slot holds
    // a result
    logic en;
    logic out_v_reg, skid_v_reg;
    logic [OUT_W-1:0] out_reg, skid_reg, res;
    logic last_valid;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // ---------------- stage 1: products ----------------
    logic signed [W-1:0]    o_in [3], d_in [3];
    logic signed [CO_W-1:0] co [3];
    logic signed [PN_W-1:0] pn [3];
    logic signed [PD_W-1:0] pd [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            o_in[k] = s_tdata[k*W +: W];
            d_in[k] = s_tdata[(k+3)*W +: W];
            co[k]   = CO_W'(cen[k]) - CO_W'(o_in[k]);
            pn[k]   = PN_W'(co[k]) * PN_W'(nrm[k]);
            pd[k]   = PD_W'(d_in[k]) * PD_W'(nrm[k]);
        end
    end

    logic                   v1_reg;
    logic signed [W-1:0]    o1_reg [3], d1_reg [3];
    logic signed [PN_W-1:0] pn1_reg [3];
    logic signed [PD_W-1:0] pd1_reg [3];

    // ---------------- stage 2: dot products ----------------
    logic                    v2_reg;
    logic signed [W-1:0]     o2_reg [3], d2_reg [3];
    logic signed [NUM_W-1:0] num2_reg, num_next;
    logic signed [DEN_W-1:0] den2_reg, den_next;

    assign num_next = NUM_W'(pn1_reg[0]) + NUM_W'(pn1_reg[1]) + NUM_W'(pn1_reg[2]);
    assign den_next = DEN_W'(pd1_reg[0]) + DEN_W'(pd1_reg[1]) + DEN_W'(pd1_reg[2]);

    // ---------------- stage 3: divider setup ----------------
    logic [NUM_W-1:0] an, an_hi;
    logic [DEN_W-1:0] ad;
    logic             live_s3, flip_s3, ovf_s3;
    logic [PWD-1:0]   pay_s3;

    always_comb
    begin
        an      = num2_reg[NUM_W-1] ? NUM_W'(-num2_reg) : NUM_W'(num2_reg);
        ad      = den2_reg[DEN_W-1] ? DEN_W'(-den2_reg) : DEN_W'(den2_reg);
        an_hi   = an >> FRAC_W;
        // quotient of (an << 16) / ad reaches 2^32 exactly when an_hi >= ad
        ovf_s3  = an_hi >= NUM_W'(ad);
        live_s3 = (num2_reg != '0) && (den2_reg != '0)
                  && (num2_reg[NUM_W-1] == den2_reg[DEN_W-1]);
        flip_s3 = !den2_reg[DEN_W-1] && (den2_reg != '0);
        for (int k = 0; k < 3; k++)
        begin
            pay_s3[k*W +: W]     = o2_reg[k];
            pay_s3[(k+3)*W +: W] = d2_reg[k];
        end
        pay_s3[6*W]   = live_s3;
        pay_s3[6*W+1] = flip_s3;
        pay_s3[6*W+2] = ovf_s3;
    end

    logic             v3_reg;
    logic [DEN_W-1:0] r03_reg, ad3_reg;
    logic [T_W-1:0]   bits3_reg;
    logic [PWD-1:0]   pay3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                o1_reg[k]  <= o_in[k];
                d1_reg[k]  <= d_in[k];
                pn1_reg[k] <= pn[k];
                pd1_reg[k] <= pd[k];
                o2_reg[k]  <= o1_reg[k];
                d2_reg[k]  <= d1_reg[k];
            end
            num2_reg  <= num_next;
            den2_reg  <= den_next;
            r03_reg   <= DEN_W'(an_hi);
            ad3_reg   <= ad;
            bits3_reg <= {an[FRAC_W-1:0], {(T_W-FRAC_W){1'b0}}};
            pay3_reg  <= pay_s3;
        end
    end

    // ---------------- divider row ----------------
    logic             dv_v    [DIV_N+1];
    logic [DEN_W-1:0] dv_rem  [DIV_N+1];
    logic [DEN_W-1:0] dv_div  [DIV_N+1];
    logic [T_W-1:0]   dv_bits [DIV_N+1];
    logic [T_W-1:0]   dv_quo  [DIV_N+1];
    logic [PWD-1:0]   dv_pay  [DIV_N+1];

    assign dv_v[0]    = v3_reg;
    assign dv_rem[0]  = r03_reg;
    assign dv_div[0]  = ad3_reg;
    assign dv_bits[0] = bits3_reg;
    assign dv_quo[0]  = '0;
    assign dv_pay[0]  = pay3_reg;

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_div
        rpai_div_cell #(
            .DW (DEN_W),
            .PW (PWD)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[i]),
            .in_rem    (dv_rem[i]),
            .in_div    (dv_div[i]),
            .in_bits   (dv_bits[i]),
            .in_quo    (dv_quo[i]),
            .in_pay    (dv_pay[i]),
            .out_valid (dv_v[i+1]),
            .out_rem   (dv_rem[i+1]),
            .out_div   (dv_div[i+1]),
            .out_bits  (dv_bits[i+1]),
            .out_quo   (dv_quo[i+1]),
            .out_pay   (dv_pay[i+1])
        );
    end

    // ---------------- stage 4: t and epsilon ----------------
    logic [T_W-1:0] t_div;
    logic [PWD-1:0] dpay;

    assign dpay  = dv_pay[DIV_N];
    assign t_div = dpay[6*W+2] ? {T_W{1'b1}} : dv_quo[DIV_N];

    logic                v4_reg, live4_reg, flip4_reg;
    logic [T_W-1:0]      t4_reg;
    logic signed [W-1:0] o4_reg [3], d4_reg [3];

    // ---------------- stage 5: t * |d| ----------------
    logic [W-1:0]       dm [3];
    logic [T_W+W-1:0]   off [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dm[k]  = d4_reg[k][W-1] ? W'(-d4_reg[k]) : W'(d4_reg[k]);
            off[k] = (T_W+W)'(t4_reg) * (T_W+W)'(dm[k]);
        end
    end

    logic                v5_reg, live5_reg, flip5_reg;
    logic [T_W-1:0]      t5_reg;
    logic [T_W+W-1:0]    off5_reg [3];
    logic signed [W-1:0] o5_reg [3];
    logic                dneg5_reg [3];

    // ---------------- stage 6: hit point ----------------
    logic signed [P_W-1:0] oext [3], offs [3], pt [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            oext[k] = P_W'(o5_reg[k]);
            offs[k] = P_W'(off5_reg[k] >> FRAC_W);
            pt[k]   = dneg5_reg[k] ? (oext[k] - offs[k]) : (oext[k] + offs[k]);
        end
    end

    logic                  v6_reg, live6_reg, flip6_reg;
    logic [T_W-1:0]        t6_reg;
    logic signed [P_W-1:0] p6_reg [3];

    // ---------------- stage 7: offsets, saturation, azimuth prep ----------------
    localparam logic signed [P_W-1:0] PMAX = {{(P_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [P_W-1:0] PMIN = {{(P_W-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [P_W:0]   dif [3];
    logic [P_W:0]          em [3];
    logic [E_W-1:0]        e_s7 [3];
    logic signed [W-1:0]   ps_s7 [3];
    logic signed [CW-1:0]  x_s7, y_s7;
    logic                  neg_s7, zero_s7;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dif[k] = (P_W+1)'(p6_reg[k]) - (P_W+1)'(cen[k]);
            em[k]  = dif[k][P_W] ? (P_W+1)'(-dif[k]) : (P_W+1)'(dif[k]);
            e_s7[k] = (em[k] > (P_W+1)'(E_MAX)) ? E_MAX : em[k][E_W-1:0];
            if (p6_reg[k] > PMAX)
                ps_s7[k] = PMAX[W-1:0];
            else if (p6_reg[k] < PMIN)
                ps_s7[k] = PMIN[W-1:0];
            else
                ps_s7[k] = p6_reg[k][W-1:0];
        end
        // azimuth is atan2(x, z): z is the CORDIC x axis, x the y axis
        neg_s7  = p6_reg[2][P_W-1];
        zero_s7 = (p6_reg[0] == '0) && (p6_reg[2] == '0);
        x_s7    = neg_s7 ? -CW'(p6_reg[2]) : CW'(p6_reg[2]);
        y_s7    = neg_s7 ? -CW'(p6_reg[0]) : CW'(p6_reg[0]);
    end

    logic                 v7_reg, live7_reg, flip7_reg, neg7_reg, zero7_reg;
    logic [T_W-1:0]       t7_reg;
    logic [E_W-1:0]       e7_reg [3];
    logic signed [W-1:0]  ps7_reg [3];
    logic signed [CW-1:0] x7_reg, y7_reg;

    // ---------------- stage 8: squares ----------------
    logic                 v8_reg, live8_reg, flip8_reg, neg8_reg, zero8_reg;
    logic [T_W-1:0]       t8_reg;
    logic [2*E_W-1:0]     sq8_reg [3];
    logic signed [W-1:0]  ps8_reg [3];
    logic signed [CW-1:0] x8_reg, y8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= dv_v[DIV_N];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_reg    <= t_div;
            live4_reg <= dpay[6*W] && (t_div > EPS_T);
            flip4_reg <= dpay[6*W+1];
            t5_reg    <= t4_reg;
            live5_reg <= live4_reg;
            flip5_reg <= flip4_reg;
            t6_reg    <= t5_reg;
            live6_reg <= live5_reg;
            flip6_reg <= flip5_reg;
            t7_reg    <= t6_reg;
            live7_reg <= live6_reg;
            flip7_reg <= flip6_reg;
            neg7_reg  <= neg_s7;
            zero7_reg <= zero_s7;
            x7_reg    <= x_s7;
            y7_reg    <= y_s7;
            t8_reg    <= t7_reg;
            live8_reg <= live7_reg;
            flip8_reg <= flip7_reg;
            neg8_reg  <= neg7_reg;
            zero8_reg <= zero7_reg;
            x8_reg    <= x7_reg;
            y8_reg    <= y7_reg;
            for (int k = 0; k < 3; k++)
            begin
                o4_reg[k]    <= dpay[k*W +: W];
                d4_reg[k]    <= dpay[(k+3)*W +: W];
                off5_reg[k]  <= off[k];
                o5_reg[k]    <= o4_reg[k];
                dneg5_reg[k] <= d4_reg[k][W-1];
                p6_reg[k]    <= pt[k];
                e7_reg[k]    <= e_s7[k];
                ps7_reg[k]   <= ps_s7[k];
                sq8_reg[k]   <= (2*E_W)'(e7_reg[k]) * (2*E_W)'(e7_reg[k]);
                ps8_reg[k]   <= ps7_reg[k];
            end
        end
    end

    // ---------------- radius test feeds the azimuth row ----------------
    logic [SQ_W-1:0] sq_sum;
    logic            rad_ok;
    logic [PWA-1:0]  pay_s9;

    always_comb
    begin
        sq_sum = SQ_W'(sq8_reg[0]) + SQ_W'(sq8_reg[1]) + SQ_W'(sq8_reg[2]);
        rad_ok = (sq_sum > SQ_W'(inner_reg)) && (sq_sum < SQ_W'(outer_reg));
        pay_s9[T_W-1:0] = t8_reg;
        for (int k = 0; k < 3; k++)
            pay_s9[T_W+k*W +: W] = ps8_reg[k];
        pay_s9[T_W+3*W]   = live8_reg && rad_ok;
        pay_s9[T_W+3*W+1] = flip8_reg;
        pay_s9[T_W+3*W+2] = neg8_reg;
        pay_s9[T_W+3*W+3] = zero8_reg;
    end

    // ---------------- normalizing cells ----------------
    logic                 nm_v   [NORM_N+1];
    logic signed [CW-1:0] nm_x   [NORM_N+1];
    logic signed [CW-1:0] nm_y   [NORM_N+1];
    logic [PWA-1:0]       nm_pay [NORM_N+1];

    assign nm_v[0]   = v8_reg;
    assign nm_x[0]   = x8_reg;
    assign nm_y[0]   = y8_reg;
    assign nm_pay[0] = pay_s9;

    for (genvar i = 0; i < NORM_N; i++)
    begin : g_norm
        // binary search of the shift, then one final doubling
        localparam int SH  = (i < NORM_N - 1) ? (32 >> i) : 1;
        localparam int LIM = (i < NORM_N - 1) ? NORM_TOP - SH : NORM_TOP;
        rpai_norm_cell #(
            .CW        (CW),
            .PW        (PWA),
            .SHIFT     (SH),
            .LIMIT_BIT (LIM)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (nm_v[i]),
            .in_x      (nm_x[i]),
            .in_y      (nm_y[i]),
            .in_pay    (nm_pay[i]),
            .out_valid (nm_v[i+1]),
            .out_x     (nm_x[i+1]),
            .out_y     (nm_y[i+1]),
            .out_pay   (nm_pay[i+1])
        );
    end

    // ---------------- CORDIC cells ----------------
    logic                 cr_v   [CORDIC_N+1];
    logic signed [CW-1:0] cr_x   [CORDIC_N+1];
    logic signed [CW-1:0] cr_y   [CORDIC_N+1];
    logic [31:0]          cr_ang [CORDIC_N+1];
    logic [PWA-1:0]       cr_pay [CORDIC_N+1];

    assign cr_v[0]   = nm_v[NORM_N];
    assign cr_x[0]   = nm_x[NORM_N];
    assign cr_y[0]   = nm_y[NORM_N];
    assign cr_pay[0] = nm_pay[NORM_N];
    assign cr_ang[0] = nm_pay[NORM_N][T_W+3*W+2] ? HALF_TURN : '0;

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_cordic
        rpai_cordic_cell #(
            .CW   (CW),
            .PW   (PWA),
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cr_v[i]),
            .in_x      (cr_x[i]),
            .in_y      (cr_y[i]),
            .in_ang    (cr_ang[i]),
            .in_pay    (cr_pay[i]),
            .out_valid (cr_v[i+1]),
            .out_x     (cr_x[i+1]),
            .out_y     (cr_y[i+1]),
            .out_ang   (cr_ang[i+1]),
            .out_pay   (cr_pay[i+1])
        );
    end

    // ---------------- azimuth window and result ----------------
    logic [PWA-1:0]  fpay;
    logic [32:0]     ang_rnd, ang_q;
    logic [PH_W-1:0] phi;
    logic            az_ok, hit;

    assign last_valid = cr_v[CORDIC_N];
    assign fpay       = cr_pay[CORDIC_N];

    always_comb
    begin
        ang_rnd = {1'b0, cr_ang[CORDIC_N]} + (33'd1 << (31 - A));
        ang_q   = ang_rnd >> (32 - A);
        // a full turn wraps to zero; the centre axis reads as zero
        if (fpay[T_W+3*W+3] || ang_q[A])
            phi = '0;
        else
            phi = PH_W'(ang_q[A-1:0]);
        az_ok = (phi >= PH_W'(az_low_reg)) && (phi <= PH_W'(az_high_reg));
        hit   = fpay[T_W+3*W] && az_ok;
        res   = '0;
        if (hit)
        begin
            res[0]       = 1'b1;
            res[32:1]    = fpay[T_W-1:0];
            res[33 +: W] = fpay[T_W +: W];
            res[33+W +: W]   = fpay[T_W+W +: W];
            res[33+2*W +: W] = fpay[T_W+2*W +: W];
            res[33+3*W]  = fpay[T_W+3*W+1];
        end
    end

    // ---------------- output register and skid slot ----------------
    logic push, pop;

    assign push = en && last_valid;
    assign pop  = out_v_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_v_reg)
                skid_v_reg <= 1'b0;
            else
                out_v_reg <= push;
        end
        else if (push)
        begin
            if (out_v_reg)
                skid_v_reg <= 1'b1;
            else
                out_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res;
        end
        else if (push)
        begin
            if (out_v_reg)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid slot holds a result while output is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready))
        else $error("skid slot filled without an output stall");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_reg[0] |-> out_reg == '0)
        else $error("miss result carries nonzero fields");

    a_hit_past_eps: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg[0] |-> out_reg[32:1] > EPS_T)
        else $error("hit reported with t at or below epsilon");
`endif

endmodule
